### src/sv39w_pkg.sv
// Shared types and constants for the Sv39 walker with A/D update.
package sv39w_pkg;

  // Item function codes
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_XLATE = 2'd2;

  // Access kinds (anything else is checked as a fetch)
  localparam logic [1:0] ACC_LOAD  = 2'd0;
  localparam logic [1:0] ACC_STORE = 2'd1;

  // Page table entry bit positions
  localparam int unsigned PTE_V   = 0;
  localparam int unsigned PTE_R   = 1;
  localparam int unsigned PTE_W   = 2;
  localparam int unsigned PTE_X   = 3;
  localparam int unsigned PTE_U   = 4;
  localparam int unsigned PTE_A   = 6;
  localparam int unsigned PTE_D   = 7;
  localparam int unsigned PPN_LSB = 10;

  // Geometry
  localparam int unsigned ENTRIES_PER_NODE = 512;
  localparam int unsigned IDX_W            = 9;
  localparam int unsigned PAGE_SHIFT       = 12;
  localparam int unsigned VPN_W            = 27;
  localparam logic [1:0]  LEVEL_TOP        = 2'd2;

  // Walker sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ_REQ,
    ST_READ_WAIT,
    ST_WALK_REQ,
    ST_WALK_EVAL,
    ST_DONE
  } walk_state_t;

  // One result transaction
  typedef struct packed {
    logic             fault;
    logic [1:0]       leaf_level;
    logic [IDX_W-1:0] idx2;
    logic [IDX_W-1:0] idx1;
    logic [IDX_W-1:0] idx0;
    logic             a_set;
    logic             d_set;
    logic [63:0]      entry;
    logic [7:0]       child;
  } res_t;

endpackage

### src/sv39_walk_ad_update.sv
// Top level: Sv39 page-table store and walker with hardware A/D update.
//
//   Channel  Direction  Handshake               Carries
//   in_      input      in_valid / in_ready     func, node, slot, entry, link, VA, kind, mode
//   out_     output     out_valid / out_ready   fault, level, indices, A/D flags, read data
//   cfg_     input      cfg_wr_en               node_count (5 bits)
//
// Each walk level is one read of the single-port-read store (ST_WALK_REQ) followed
// by one evaluate state (ST_WALK_EVAL) that also writes A/D back to the leaf; a walk
// that reaches a node out of use stops there, without the evaluate state.
// Reset clears control and node_count; the store itself is not cleared.
// A new transaction is taken while the previous result still waits in the
// output register; a result that cannot enter that register holds the sequencer.
module sv39_walk_ad_update #(
  parameter int NODE_COUNT_MAX = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // configuration
  input  logic                     cfg_wr_en,
  input  logic [4:0]               cfg_wr_data,
  // input channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_func,
  input  logic [3:0]               in_node,
  input  logic [sv39w_pkg::IDX_W-1:0] in_slot,
  input  logic [63:0]              in_entry_value,
  input  logic [7:0]               in_child_link,
  input  logic [38:0]              in_virtual_address,
  input  logic [1:0]               in_access_kind,
  input  logic                     in_privilege_mode,
  // result channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_fault,
  output logic [1:0]               out_leaf_level,
  output logic [sv39w_pkg::IDX_W-1:0] out_index_level2,
  output logic [sv39w_pkg::IDX_W-1:0] out_index_level1,
  output logic [sv39w_pkg::IDX_W-1:0] out_index_level0,
  output logic                     out_accessed_set,
  output logic                     out_dirty_set,
  output logic [63:0]              out_entry_out,
  output logic [7:0]               out_child_out
);
  import sv39w_pkg::*;

  localparam int NW    = (NODE_COUNT_MAX > 1) ? $clog2(NODE_COUNT_MAX) : 1;
  localparam int AW    = NW + IDX_W;
  localparam int DEPTH = (1 << AW);
  localparam int RW    = 72;
  localparam logic [8:0] NMAX = 9'(NODE_COUNT_MAX);

  walk_state_t state_r, state_nxt;

  logic [4:0]       node_count_r;
  logic [3:0]       node_r;
  logic [IDX_W-1:0] slot_r;
  logic [63:0]      wval_r;
  logic [7:0]       wchild_r;
  logic [VPN_W-1:0] vpn_r, vpn_nxt;
  logic [1:0]       kind_r;
  logic             mode_r;
  logic [1:0]       level_r, level_nxt;
  logic [7:0]       ptr_r, ptr_nxt;
  logic [AW-1:0]    walk_addr_r, walk_addr_nxt;
  logic [IDX_W-1:0] idx2_r, idx2_nxt, idx1_r, idx1_nxt, idx0_r, idx0_nxt;
  res_t             res_r, res_nxt;
  res_t             out_r;
  logic             out_valid_r;

  logic             in_acc, out_free;
  logic             node_ok, ptr_ok;
  logic [IDX_W-1:0] lvl_idx;
  logic [AW-1:0]    user_addr, ptr_addr;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [RW-1:0]    ram_wdata, ram_rdata;

  logic [63:0]      ev_e;
  logic [7:0]       ev_child;
  logic             ev_bad, ev_leaf, ev_misal, ev_ubad, ev_perm, ev_ok;
  logic             ev_aset, ev_dset;
  logic [63:0]      ev_new;

  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Range checks for user node and walk pointer
  assign node_ok = 9'(node_r) < NMAX;
  assign ptr_ok  = (9'(ptr_r) < 9'(node_count_r)) && (9'(ptr_r) < NMAX);

  // Pick the VPN slice for the current level
  always_comb begin
    unique case (level_r)
      2'd2:    lvl_idx = vpn_r[3*IDX_W-1:2*IDX_W];
      2'd1:    lvl_idx = vpn_r[2*IDX_W-1:IDX_W];
      default: lvl_idx = vpn_r[IDX_W-1:0];
    endcase
  end

  assign user_addr = {NW'(node_r), slot_r};
  assign ptr_addr  = {NW'(ptr_r), lvl_idx};

  // Decode the entry returned for the current walk level
  always_comb begin
    ev_e     = ram_rdata[63:0];
    ev_child = ram_rdata[71:64];
    ev_bad   = !ev_e[PTE_V] || (!ev_e[PTE_R] && ev_e[PTE_W]);
    ev_leaf  = ev_e[PTE_R] || ev_e[PTE_X];
    unique case (level_r)
      2'd2:    ev_misal = ev_e[PPN_LSB +: 2*IDX_W] != '0;
      2'd1:    ev_misal = ev_e[PPN_LSB +: IDX_W] != '0;
      default: ev_misal = 1'b0;
    endcase
    ev_ubad = ev_e[PTE_U] != !mode_r;
    unique case (kind_r)
      ACC_LOAD:  ev_perm = ev_e[PTE_R];
      ACC_STORE: ev_perm = ev_e[PTE_W];
      default:   ev_perm = ev_e[PTE_X];
    endcase
    ev_ok   = !ev_bad && ev_leaf && !ev_misal && !ev_ubad && ev_perm;
    ev_aset = !ev_e[PTE_A];
    ev_dset = (kind_r == ACC_STORE) && !ev_e[PTE_D];
    ev_new  = ev_e;
    ev_new[PTE_A] = 1'b1;
    if (kind_r == ACC_STORE) begin
      ev_new[PTE_D] = 1'b1;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_func)
            FUNC_WRITE: state_nxt = ST_WRITE;
            FUNC_READ:  state_nxt = ST_READ_REQ;
            FUNC_XLATE: state_nxt = ST_WALK_REQ;
            default:    state_nxt = ST_DONE;
          endcase
        end
      end
      ST_WRITE:     state_nxt = ST_DONE;
      ST_READ_REQ:  state_nxt = node_ok ? ST_READ_WAIT : ST_DONE;
      ST_READ_WAIT: state_nxt = ST_DONE;
      ST_WALK_REQ:  state_nxt = ptr_ok ? ST_WALK_EVAL : ST_DONE;
      ST_WALK_EVAL: begin
        if (!ev_bad && !ev_leaf && level_r != 2'd0) begin
          state_nxt = ST_WALK_REQ;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE:      state_nxt = out_free ? ST_IDLE : ST_DONE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Handshake and store controls
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = user_addr;
    ram_wdata = {wchild_r, wval_r};
    ram_re    = 1'b0;
    ram_raddr = user_addr;
    unique case (state_r)
      ST_IDLE:      in_ready = 1'b1;
      ST_WRITE:     ram_we = node_ok;
      ST_READ_REQ:  ram_re = node_ok;
      ST_WALK_REQ: begin
        ram_re    = ptr_ok;
        ram_raddr = ptr_addr;
      end
      ST_WALK_EVAL: begin
        ram_we    = ev_ok;
        ram_waddr = walk_addr_r;
        ram_wdata = {ev_child, ev_new};
      end
      default: ;
    endcase
  end

  // Walk datapath and result assembly
  always_comb begin
    vpn_nxt       = vpn_r;
    level_nxt     = level_r;
    ptr_nxt       = ptr_r;
    walk_addr_nxt = walk_addr_r;
    idx2_nxt      = idx2_r;
    idx1_nxt      = idx1_r;
    idx0_nxt      = idx0_r;
    res_nxt       = res_r;
    unique case (state_r)
      ST_IDLE: begin
        vpn_nxt   = in_virtual_address[38:PAGE_SHIFT];
        level_nxt = LEVEL_TOP;
        ptr_nxt   = '0;
        idx2_nxt  = '0;
        idx1_nxt  = '0;
        idx0_nxt  = '0;
        res_nxt   = '0;
      end
      ST_READ_WAIT: begin
        res_nxt.entry = ram_rdata[63:0];
        res_nxt.child = ram_rdata[71:64];
      end
      ST_WALK_REQ: begin
        walk_addr_nxt = ptr_addr;
        unique case (level_r)
          2'd2:    idx2_nxt = lvl_idx;
          2'd1:    idx1_nxt = lvl_idx;
          default: idx0_nxt = lvl_idx;
        endcase
        if (!ptr_ok) begin
          res_nxt.fault = 1'b1;
        end
      end
      ST_WALK_EVAL: begin
        if (ev_ok) begin
          res_nxt.leaf_level = level_r;
          res_nxt.idx2       = idx2_r;
          res_nxt.idx1       = idx1_r;
          res_nxt.idx0       = idx0_r;
          res_nxt.a_set      = ev_aset;
          res_nxt.d_set      = ev_dset;
        end else if (!ev_bad && !ev_leaf && level_r != 2'd0) begin
          ptr_nxt   = ev_child;
          level_nxt = level_r - 2'd1;
        end else begin
          res_nxt.fault = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      node_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        node_count_r <= cfg_wr_data;
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      node_r   <= in_node;
      slot_r   <= in_slot;
      wval_r   <= in_entry_value;
      wchild_r <= in_child_link;
      kind_r   <= in_access_kind;
      mode_r   <= in_privilege_mode;
    end
    vpn_r       <= vpn_nxt;
    level_r     <= level_nxt;
    ptr_r       <= ptr_nxt;
    walk_addr_r <= walk_addr_nxt;
    idx2_r      <= idx2_nxt;
    idx1_r      <= idx1_nxt;
    idx0_r      <= idx0_nxt;
    res_r       <= res_nxt;
    if (state_r == ST_DONE && out_free) begin
      out_r <= res_r;
    end
  end

  // Node store: entry in the low 64 bits, child link above
  sv39w_ram #(
    .WIDTH(RW),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Drive result ports
  assign out_valid        = out_valid_r;
  assign out_fault        = out_r.fault;
  assign out_leaf_level   = out_r.leaf_level;
  assign out_index_level2 = out_r.idx2;
  assign out_index_level1 = out_r.idx1;
  assign out_index_level0 = out_r.idx0;
  assign out_accessed_set = out_r.a_set;
  assign out_dirty_set    = out_r.d_set;
  assign out_entry_out    = out_r.entry;
  assign out_child_out    = out_r.child;

endmodule

### src/sv39w_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module sv39w_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/sv39w_checker.sv
// Port-level checker for the Sv39 walker, bound to the top level.
module sv39w_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_wr_en,
  input logic [4:0]  cfg_wr_data,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_func,
  input logic [3:0]  in_node,
  input logic [8:0]  in_slot,
  input logic [63:0] in_entry_value,
  input logic [7:0]  in_child_link,
  input logic [38:0] in_virtual_address,
  input logic [1:0]  in_access_kind,
  input logic        in_privilege_mode,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_fault,
  input logic [1:0]  out_leaf_level,
  input logic [8:0]  out_index_level2,
  input logic [8:0]  out_index_level1,
  input logic [8:0]  out_index_level0,
  input logic        out_accessed_set,
  input logic        out_dirty_set,
  input logic [63:0] out_entry_out,
  input logic [7:0]  out_child_out
);

  logic [1:0] pend_r;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Count transactions taken but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 2'(in_acc) - 2'(out_acc);
    end
  end

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_fault) &&
      $stable(out_entry_out) && $stable(out_child_out) && $stable(out_index_level2))
    else $error("result changed while stalled");

  // A fault carries nothing else
  a_fault_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fault |-> out_leaf_level == 2'd0 && out_index_level2 == 9'd0 &&
      out_index_level1 == 9'd0 && out_index_level0 == 9'd0 && !out_accessed_set &&
      !out_dirty_set && out_entry_out == 64'd0 && out_child_out == 8'd0)
    else $error("faulting result has non-zero fields");

  // One transaction at a time through the walker
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("input taken on consecutive cycles");

  // Never deliver a result without a transaction behind it
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result without a pending transaction");

  // Dirty set only alongside a successful leaf
  a_dirty_leaf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dirty_set |-> !out_fault && out_leaf_level != 2'd3)
    else $error("dirty flag on a bad result");

endmodule

bind sv39_walk_ad_update sv39w_checker u_sv39w_checker (.*);

### tb/tb_sv39_walk_ad_update.sv
// Self-checking testbench for the Sv39 page-table store and walker with A/D update.
module tb_sv39_walk_ad_update;
  timeunit 1ns;
  timeprecision 1ps;
  import sv39w_pkg::*;

  localparam int NODES        = 16;
  localparam int STORE_SLOTS  = NODES * ENTRIES_PER_NODE;
  localparam int STALL_LIMIT  = 4000;
  localparam int SETTLE       = 12;
  localparam int PHASE_ITEMS  = 210;

  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam logic [1:0] ACC_FETCH  = 2'd2;
  localparam logic [1:0] ACC_SPARE  = 2'd3;
  localparam logic       MODE_USER  = 1'b0;
  localparam logic       MODE_SUPER = 1'b1;

  localparam logic [7:0] FL_V = 8'h01;
  localparam logic [7:0] FL_R = 8'h02;
  localparam logic [7:0] FL_W = 8'h04;
  localparam logic [7:0] FL_X = 8'h08;
  localparam logic [7:0] FL_U = 8'h10;

  typedef struct {
    logic [1:0]       func;
    logic [3:0]       node;
    logic [IDX_W-1:0] slot;
    logic [63:0]      entry;
    logic [7:0]       link;
    logic [38:0]      va;
    logic [1:0]       kind;
    logic             mode;
  } walk_req_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en = 1'b0;
  logic [4:0]       cfg_wr_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [1:0]       in_func = '0;
  logic [3:0]       in_node = '0;
  logic [IDX_W-1:0] in_slot = '0;
  logic [63:0]      in_entry_value = '0;
  logic [7:0]       in_child_link = '0;
  logic [38:0]      in_virtual_address = '0;
  logic [1:0]       in_access_kind = '0;
  logic             in_privilege_mode = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             out_fault;
  logic [1:0]       out_leaf_level;
  logic [IDX_W-1:0] out_index_level2;
  logic [IDX_W-1:0] out_index_level1;
  logic [IDX_W-1:0] out_index_level0;
  logic             out_accessed_set;
  logic             out_dirty_set;
  logic [63:0]      out_entry_out;
  logic [7:0]       out_child_out;

  // Transactions waiting to be driven and results awaited from the walker
  walk_req_t pending_reqs[$];
  res_t      awaited_res[$];

  // Predictor copy of the node store and node_count
  logic [63:0] pt_entry [STORE_SLOTS];
  logic [7:0]  pt_link  [STORE_SLOTS];
  logic [4:0]  pt_nodes = '0;

  // Generator shadow: what has been written, used to keep walks on written entries
  logic [63:0] gen_entry   [STORE_SLOTS];
  logic [7:0]  gen_link    [STORE_SLOTS];
  bit          gen_written [STORE_SLOTS];
  int          filled_addrs[$];
  int          gen_nodes = 0;
  logic [IDX_W-1:0] idx_pool [4];

  int  items_pushed = 0;
  int  results_seen = 0;
  int  mismatches = 0;
  int  idle_cycles = 0;
  int  in_gap = 0;
  int  out_gap = 0;
  bit  in_took = 1'b0;
  bit  quiet = 1'b0;
  walk_req_t drv;
  int  node_settings [7] = '{1, 15, 4, 0, 16, 7, 16};

  sv39_walk_ad_update dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_node            (in_node),
    .in_slot            (in_slot),
    .in_entry_value     (in_entry_value),
    .in_child_link      (in_child_link),
    .in_virtual_address (in_virtual_address),
    .in_access_kind     (in_access_kind),
    .in_privilege_mode  (in_privilege_mode),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_fault          (out_fault),
    .out_leaf_level     (out_leaf_level),
    .out_index_level2   (out_index_level2),
    .out_index_level1   (out_index_level1),
    .out_index_level0   (out_index_level0),
    .out_accessed_set   (out_accessed_set),
    .out_dirty_set      (out_dirty_set),
    .out_entry_out      (out_entry_out),
    .out_child_out      (out_child_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one transaction to the predicted store and return its result
  function automatic res_t step_table(input walk_req_t rq);
    res_t             r;
    int               addr;
    int               nd;
    int               lv;
    bit               done;
    bit               ok;
    logic [63:0]      e;
    logic [IDX_W-1:0] ix;
    logic [IDX_W-1:0] vpn [3];
    r = '0;
    addr = {rq.node, rq.slot};
    case (rq.func)
      FUNC_WRITE: begin
        pt_entry[addr] = rq.entry;
        pt_link[addr] = rq.link;
      end
      FUNC_READ: begin
        r.entry = pt_entry[addr];
        r.child = pt_link[addr];
      end
      FUNC_XLATE: begin
        nd = 0;
        lv = 2;
        done = 1'b0;
        vpn = '{default: '0};
        while (!done) begin
          done = 1'b1;
          if (nd >= pt_nodes || nd >= NODES) begin
            r.fault = 1'b1;
          end else begin
            ix = rq.va[PAGE_SHIFT + IDX_W*lv +: IDX_W];
            vpn[lv] = ix;
            addr = nd * ENTRIES_PER_NODE + ix;
            e = pt_entry[addr];
            if (!e[PTE_V] || (!e[PTE_R] && e[PTE_W])) begin
              r.fault = 1'b1;
            end else if (e[PTE_R] || e[PTE_X]) begin
              // leaf: alignment, U bit against mode, then permission
              if ((lv == 2 && e[PPN_LSB +: 2*IDX_W] != '0) ||
                  (lv == 1 && e[PPN_LSB +: IDX_W] != '0)) begin
                r.fault = 1'b1;
              end else if (e[PTE_U] == rq.mode) begin
                r.fault = 1'b1;
              end else begin
                case (rq.kind)
                  ACC_LOAD:  ok = e[PTE_R];
                  ACC_STORE: ok = e[PTE_W];
                  default:   ok = e[PTE_X];
                endcase
                if (!ok) begin
                  r.fault = 1'b1;
                end else begin
                  r.leaf_level = 2'(lv);
                  r.idx2 = vpn[2];
                  r.idx1 = vpn[1];
                  r.idx0 = vpn[0];
                  r.a_set = !e[PTE_A];
                  r.d_set = (rq.kind == ACC_STORE) && !e[PTE_D];
                  e[PTE_A] = 1'b1;
                  if (rq.kind == ACC_STORE) e[PTE_D] = 1'b1;
                  pt_entry[addr] = e;
                end
              end
            end else if (lv == 0) begin
              r.fault = 1'b1;
            end else begin
              nd = pt_link[addr];
              lv--;
              done = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0h want %0h",
                                results_seen, name, got, want));
  endtask

  // Sample handshakes: track config, predict accepted items, check results
  always @(posedge clk) begin : monitor
    walk_req_t seen;
    res_t      want;
    if (!rst_n) begin
      pt_nodes = '0;
    end else begin
      if (cfg_wr_en) pt_nodes = cfg_wr_data;
      if (in_valid && in_ready) begin
        in_took = 1'b1;
        seen = '{in_func, in_node, in_slot, in_entry_value, in_child_link,
                 in_virtual_address, in_access_kind, in_privilege_mode};
        awaited_res.push_back(step_table(seen));
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (awaited_res.size() == 0) begin
          report_mismatch("result arrived with none awaited");
        end else begin
          want = awaited_res.pop_front();
          check_field("fault", out_fault, want.fault);
          check_field("leaf_level", out_leaf_level, want.leaf_level);
          check_field("index_level2", out_index_level2, want.idx2);
          check_field("index_level1", out_index_level1, want.idx1);
          check_field("index_level0", out_index_level0, want.idx0);
          check_field("accessed_set", out_accessed_set, want.a_set);
          check_field("dirty_set", out_dirty_set, want.d_set);
          check_field("entry_out", out_entry_out, want.entry);
          check_field("child_out", out_child_out, want.child);
        end
      end
    end
  end

  // Drive the next pending transaction, holding it until accepted
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      in_took = 1'b0;
      if (in_gap != 0 || pending_reqs.size() == 0) begin
        if (in_gap != 0) in_gap--;
        in_valid <= 1'b0;
      end else begin
        drv = pending_reqs.pop_front();
        in_func <= drv.func;
        in_node <= drv.node;
        in_slot <= drv.slot;
        in_entry_value <= drv.entry;
        in_child_link <= drv.link;
        in_virtual_address <= drv.va;
        in_access_kind <= drv.kind;
        in_privilege_mode <= drv.mode;
        in_valid <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 3);
      end
    end
  end

  // Stall the result channel in short random bursts
  always @(negedge clk) begin
    if (out_gap != 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!quiet && $urandom_range(0, 4) == 0) out_gap = $urandom_range(1, 3);
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n && !(in_valid && in_ready) && !(out_valid && out_ready)) idle_cycles++;
    else idle_cycles = 0;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL sv39_walk_ad_update");
      $finish;
    end
  end

  function automatic logic [63:0] pte_of(input logic [43:0] ppn, input logic [7:0] flags);
    return {10'd0, ppn, 2'd0, flags};
  endfunction

  function automatic logic [38:0] va_of(input int i2, input int i1, input int i0);
    return {9'(i2), 9'(i1), 9'(i0), 12'($urandom)};
  endfunction

  // Follow the shadow tables; report the first unwritten entry the walk would read
  function automatic bit path_gap(input logic [38:0] va, output int gap_addr,
                                  output int gap_lvl);
    int          nd;
    int          lv;
    int          addr;
    logic [63:0] e;
    nd = 0;
    gap_addr = 0;
    gap_lvl = 0;
    for (lv = 2; lv >= 0; lv--) begin
      if (nd >= gen_nodes || nd >= NODES) return 1'b0;
      addr = nd * ENTRIES_PER_NODE + va[PAGE_SHIFT + IDX_W*lv +: IDX_W];
      if (!gen_written[addr]) begin
        gap_addr = addr;
        gap_lvl = lv;
        return 1'b1;
      end
      e = gen_entry[addr];
      // anything but a valid pointer ends the walk here
      if (!e[PTE_V] || e[PTE_R] || e[PTE_W] || e[PTE_X]) return 1'b0;
      nd = gen_link[addr];
    end
    return 1'b0;
  endfunction

  // Random entry for a given level: mostly pointers and leaves, some broken
  function automatic void make_pte(input int lvl, output logic [63:0] e,
                                   output logic [7:0] link);
    int pick;
    e = {$urandom, $urandom};
    link = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 7) begin
      e[PTE_V] = 1'b0;
    end else if (pick < 11) begin
      e[PTE_V] = 1'b1;
      e[PTE_R] = 1'b0;
      e[PTE_W] = 1'b1;
    end else if ((lvl > 0 && pick < 55) || (lvl == 0 && pick < 15)) begin
      e[PTE_X:PTE_V] = 4'b0001;
      if (gen_nodes > 0 && $urandom_range(0, 7) != 0)
        link = 8'($urandom_range(0, gen_nodes - 1));
    end else begin
      e[PTE_V] = 1'b1;
      if (!e[PTE_R]) begin
        e[PTE_X] = 1'b1;
        e[PTE_W] = 1'b0;
      end
      if ($urandom_range(0, 5) != 0) begin
        if (lvl == 2) e[PPN_LSB +: 2*IDX_W] = '0;
        if (lvl == 1) e[PPN_LSB +: IDX_W] = '0;
      end
    end
  endfunction

  task automatic push_req(input walk_req_t t);
    pending_reqs.push_back(t);
    items_pushed++;
  endtask

  task automatic queue_write(input int addr, input logic [63:0] e, input logic [7:0] link);
    walk_req_t t;
    t = '{FUNC_WRITE, 4'(addr >> IDX_W), 9'(addr), e, link, 39'($urandom),
          2'($urandom), 1'($urandom)};
    if (!gen_written[addr]) filled_addrs.push_back(addr);
    gen_written[addr] = 1'b1;
    gen_entry[addr] = e;
    gen_link[addr] = link;
    push_req(t);
  endtask

  task automatic queue_read(input int addr);
    walk_req_t t;
    t = '{FUNC_READ, 4'(addr >> IDX_W), 9'(addr), {$urandom, $urandom}, 8'($urandom),
          39'($urandom), 2'($urandom), 1'($urandom)};
    push_req(t);
  endtask

  // Fill any unwritten entry on the path first, then translate
  task automatic queue_xlate(input logic [38:0] va, input logic [1:0] kind, input logic mode);
    walk_req_t   t;
    int          gap_addr;
    int          gap_lvl;
    logic [63:0] e;
    logic [7:0]  link;
    while (path_gap(va, gap_addr, gap_lvl)) begin
      make_pte(gap_lvl, e, link);
      queue_write(gap_addr, e, link);
    end
    t = '{FUNC_XLATE, 4'($urandom), 9'($urandom), {$urandom, $urandom}, 8'($urandom),
          va, kind, mode};
    push_req(t);
  endtask

  task automatic wait_drained();
    while (results_seen < items_pushed) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_node_count(input int value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= 5'(value);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    gen_nodes = value;
  endtask

  // One phase of random traffic, mostly walks over a small set of indices
  task automatic random_phase(input int count);
    int               roll;
    int               addr;
    int               nd;
    logic [38:0]      va;
    logic [63:0]      e;
    logic [7:0]       link;
    walk_req_t        t;
    idx_pool = '{9'd0, 9'd511, 9'($urandom), 9'($urandom)};
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
        va = 39'({$urandom, $urandom});
        if ($urandom_range(0, 9) != 0)
          va[38:12] = {idx_pool[$urandom_range(0, 3)], idx_pool[$urandom_range(0, 3)],
                       idx_pool[$urandom_range(0, 3)]};
        queue_xlate(va, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end else if (roll < 65) begin
        queue_read(filled_addrs[$urandom_range(0, filled_addrs.size() - 1)]);
      end else if (roll < 80) begin
        nd = (gen_nodes > 0) ? $urandom_range(0, gen_nodes - 1) : $urandom_range(0, NODES - 1);
        addr = nd * ENTRIES_PER_NODE + idx_pool[$urandom_range(0, 3)];
        make_pte($urandom_range(0, 2), e, link);
        queue_write(addr, e, link);
      end else if (roll < 95) begin
        queue_write($urandom_range(0, STORE_SLOTS - 1), {$urandom, $urandom}, 8'($urandom));
      end else begin
        t = '{FUNC_SPARE, 4'($urandom), 9'($urandom), {$urandom, $urandom}, 8'($urandom),
              39'({$urandom, $urandom}), 2'($urandom), 1'($urandom)};
        push_req(t);
      end
    end
  endtask

  initial begin
    walk_req_t t;
    // With node_count still at reset: extremes of write and read, unused func,
    // and a walk that faults at the root
    queue_write(STORE_SLOTS - 1, '1, 8'hFF);
    queue_write(0, '0, 8'h00);
    queue_read(STORE_SLOTS - 1);
    queue_read(0);
    t = '{FUNC_SPARE, 4'hF, 9'h1FF, '1, 8'hFF, '1, ACC_SPARE, 1'b1};
    push_req(t);
    queue_xlate('1, ACC_LOAD, MODE_SUPER);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    wait_drained();
    write_node_count(16);

    // Gigapage leaf: A then D set, then nothing new
    queue_write(1, pte_of(44'h4_0000, FL_V | FL_R | FL_W | FL_X), 8'd0);
    queue_xlate(va_of(1, 0, 0), ACC_LOAD, MODE_SUPER);
    queue_xlate(va_of(1, 3, 5), ACC_STORE, MODE_SUPER);
    queue_xlate(va_of(1, 511, 511), ACC_STORE, MODE_SUPER);
    // Misaligned gigapage, invalid entry, reserved W without R
    queue_write(2, pte_of(44'h1, FL_V | FL_R), 8'd0);
    queue_xlate(va_of(2, 0, 0), ACC_LOAD, MODE_SUPER);
    queue_write(3, '0, 8'd0);
    queue_xlate(va_of(3, 0, 0), ACC_LOAD, MODE_SUPER);
    queue_write(4, pte_of(44'h0, FL_V | FL_W), 8'd0);
    queue_xlate(va_of(4, 0, 0), ACC_STORE, MODE_SUPER);
    // Pointer into a node out of use
    queue_write(5, pte_of(44'h0, FL_V), 8'd20);
    queue_xlate(va_of(5, 0, 0), ACC_LOAD, MODE_SUPER);
    // Three-level walk to a user page: fetch and spare kind pass, store and supervisor fault
    queue_write(6, pte_of(44'h0, FL_V), 8'd1);
    queue_write(ENTRIES_PER_NODE + 7, pte_of(44'h0, FL_V), 8'd2);
    queue_write(2 * ENTRIES_PER_NODE + 8, pte_of(44'hABCDE, FL_V | FL_R | FL_X | FL_U), 8'd0);
    queue_xlate(va_of(6, 7, 8), ACC_FETCH, MODE_USER);
    queue_xlate(va_of(6, 7, 8), ACC_STORE, MODE_USER);
    queue_xlate(va_of(6, 7, 8), ACC_LOAD, MODE_SUPER);
    queue_xlate(va_of(6, 7, 8), ACC_SPARE, MODE_USER);
    // Pointer at the last level runs out of levels
    queue_write(2 * ENTRIES_PER_NODE + 9, pte_of(44'h0, FL_V), 8'd0);
    queue_xlate(va_of(6, 7, 9), ACC_LOAD, MODE_SUPER);
    // Megapage: misaligned faults, aligned sets A and D
    queue_write(ENTRIES_PER_NODE + 10, pte_of(44'h3, FL_V | FL_R | FL_W), 8'd0);
    queue_xlate(va_of(6, 10, 0), ACC_LOAD, MODE_SUPER);
    queue_write(ENTRIES_PER_NODE + 11, pte_of(44'h200, FL_V | FL_R | FL_W | FL_U), 8'd0);
    queue_xlate(va_of(6, 11, 77), ACC_STORE, MODE_USER);
    // Read back leaves after hardware A/D update
    queue_read(1);
    queue_read(ENTRIES_PER_NODE + 11);

    // Random phases, idle and reconfigured in between; the last runs without gaps
    foreach (node_settings[p]) begin
      wait_drained();
      write_node_count(node_settings[p]);
      if (p == $size(node_settings) - 1) quiet = 1'b1;
      random_phase(PHASE_ITEMS);
    end

    wait_drained();
    repeat (20) @(negedge clk);
    if (awaited_res.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", awaited_res.size()));
    if (mismatches == 0) begin
      $display("PASS sv39_walk_ad_update");
    end else begin
      $display("FAIL sv39_walk_ad_update");
    end
    $finish;
  end

endmodule

### sv39_walk_ad_update.f
src/sv39w_pkg.sv
src/sv39w_ram.sv
src/sv39_walk_ad_update.sv
src/sv39w_checker.sv
tb/tb_sv39_walk_ad_update.sv
